>>> rtl/core/tbrc_pkg.sv
// Types, codes and constants shared by the trace buffer ring controller.
// No dependencies.
`default_nettype none

package tbrc_pkg;

    localparam int DEF_MAX_BUFFERS        = 16;
    localparam int DEF_TIMED_HEADER_BYTES = 12;
    localparam int UNTIMED_HEADER_BYTES   = 4;

    // width for ring lengths and pointer compares, holds values up to 511
    localparam int CNT_W = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_TIMES       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_BUF         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_IN_USE = 3'd4;

    localparam logic [15:0] RESET_BUFFER_BYTES   = 16'd4096;
    localparam logic [4:0]  RESET_BUFFERS_IN_USE = 5'd16;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_DUMP       = 2'd1,
        OP_DUMP_FORCE = 2'd2,
        OP_RESET      = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_LOST_BLOCKED = 3'd1,
        ST_LOST_BIG     = 3'd2,
        ST_IGNORED      = 3'd3,
        ST_DUMPED       = 3'd4,
        ST_FORCED       = 3'd5,
        ST_NONE_READY   = 3'd6
    } t_status;

    typedef struct packed {
        logic        trace_enable;
        logic        no_times;
        logic        no_buf;
        logic [15:0] buffer_bytes;
        logic [4:0]  buffers_in_use;
    } t_cfg;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] record_bytes;
        logic [15:0] record_flags;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  buffer_index;
        logic [15:0] write_offset;
        logic [31:0] header_word;
        logic [4:0]  header_bytes_used;
        logic        flushed;
        logic [15:0] dump_bytes;
        logic [13:0] dump_records;
        logic [15:0] dump_lost;
        logic [31:0] total_records;
        logic [31:0] total_lost;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/trace_buffer_ring_controller.sv
// Trace buffer ring controller: places trace records into a ring of buffers and
// hands out filled buffers on dump. One word per cycle sustained while the receiver
// keeps up; a word waits in the input register while the core decides it, and when it
// is taken the ring pointers, counters and per-buffer tables update and the result
// register loads at the same edge. The input stalls only while both registers hold
// words and the receiver holds off. The state update in the core sets the rate.
// Depends on tbrc_pkg and the tbrc_* submodules.
`default_nettype none

module trace_buffer_ring_controller
    import tbrc_pkg::*;
#(
    parameter int MAX_BUFFERS        = DEF_MAX_BUFFERS,
    parameter int TIMED_HEADER_BYTES = DEF_TIMED_HEADER_BYTES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // record_bytes[15:0], record_flags[31:16]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // buffer_index[3:0], write_offset[19:4], header_word[51:20],
    // header_bytes_used[56:52], flushed[57], dump_bytes[73:58],
    // dump_records[87:74], dump_lost[103:88], total_records[135:104],
    // total_lost[167:136]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[2:0]
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_result;
    logic    w_in_valid;
    logic    w_out_ready;
    logic    w_fire;

    assign w_fire = w_in_valid && w_out_ready;

    tbrc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tbrc_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_take   (w_fire),
        .o_valid  (w_in_valid),
        .o_item   (w_item)
    );

    tbrc_core #(
        .MAX_BUFFERS        (MAX_BUFFERS),
        .TIMED_HEADER_BYTES (TIMED_HEADER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_item   (w_item),
        .o_result (w_result)
    );

    tbrc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_result (w_result),
        .o_ready  (w_out_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_fire_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> m_axis_tvalid)
        else $error("decided word did not reach the result register");

    a_stored_header_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_result.status == ST_STORED) |->
            (w_result.header_bytes_used == 5'(UNTIMED_HEADER_BYTES)) ||
            (w_result.header_bytes_used == 5'(TIMED_HEADER_BYTES)))
        else $error("stored record with bad header length");

    a_flush_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_result.flushed |->
            (w_result.status == ST_STORED) || (w_result.status == ST_LOST_BLOCKED) ||
            (w_result.status == ST_FORCED))
        else $error("buffer closed on a word that cannot close one");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tbrc_cfg_regs.sv
// Configuration registers of the trace buffer ring controller.
// Depends on tbrc_pkg.
`default_nettype none

module tbrc_cfg_regs
    import tbrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trace_enable   <= 1'b0;
            r_cfg.no_times       <= 1'b0;
            r_cfg.no_buf         <= 1'b0;
            r_cfg.buffer_bytes   <= RESET_BUFFER_BYTES;
            r_cfg.buffers_in_use <= RESET_BUFFERS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRACE_ENABLE:   r_cfg.trace_enable   <= i_cfg_data[0];
                CFG_NO_TIMES:       r_cfg.no_times       <= i_cfg_data[0];
                CFG_NO_BUF:         r_cfg.no_buf         <= i_cfg_data[0];
                CFG_BUFFER_BYTES:   r_cfg.buffer_bytes   <= i_cfg_data[15:0];
                CFG_BUFFERS_IN_USE: r_cfg.buffers_in_use <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/tbrc_in_stage.sv
// Input register of the trace buffer ring controller: unpacks and holds one word.
// Depends on tbrc_pkg.
`default_nettype none

module tbrc_in_stage
    import tbrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tvalid,
    output logic                       o_tready,
    input  wire logic [IN_TDATA_W-1:0] i_tdata,
    input  wire logic [IN_TUSER_W-1:0] i_tuser,
    input  wire logic                  i_take,
    output logic                       o_valid,
    output t_item                      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tvalid && o_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tvalid && o_tready) begin
            r_item.opcode       <= t_opcode'(i_tuser);
            r_item.record_bytes <= i_tdata[15:0];
            r_item.record_flags <= i_tdata[31:16];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> rtl/core/tbrc_core.sv
// Ring state and per-word decision logic of the trace buffer ring controller.
// Depends on tbrc_pkg.
`default_nettype none

module tbrc_core
    import tbrc_pkg::*;
#(
    parameter int MAX_BUFFERS        = DEF_MAX_BUFFERS,
    parameter int TIMED_HEADER_BYTES = DEF_TIMED_HEADER_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    output t_result    o_result
);

    localparam int                PW      = $clog2(MAX_BUFFERS);
    localparam logic [CNT_W-1:0]  MAX_LEN = CNT_W'(MAX_BUFFERS);
    localparam logic [16:0]       THB     = 17'(TIMED_HEADER_BYTES);
    localparam logic [4:0]        HB_T    = 5'(TIMED_HEADER_BYTES);
    localparam logic [4:0]        HB_U    = 5'(UNTIMED_HEADER_BYTES);

    logic [PW-1:0] r_oldest,    n_oldest;
    logic [PW-1:0] r_filling,   n_filling;
    logic [15:0]   r_fill_off,  n_fill_off;
    logic          r_blocked,   n_blocked;
    logic [15:0]   r_lost_pend, n_lost_pend;
    logic [31:0]   r_offered,   n_offered;
    logic [31:0]   r_lost,      n_lost;
    logic [15:0]   r_size [MAX_BUFFERS];
    logic [15:0]   n_size [MAX_BUFFERS];
    logic [13:0]   r_recs [MAX_BUFFERS];
    logic [13:0]   n_recs [MAX_BUFFERS];
    logic [15:0]   r_blost [MAX_BUFFERS];
    logic [15:0]   n_blost [MAX_BUFFERS];

    logic [CNT_W-1:0] w_len;
    logic [16:0]      w_size;
    logic [16:0]      w_need;
    logic [17:0]      w_room;
    logic [PW-1:0]    w_next_fill;
    logic [PW-1:0]    w_next_old;
    logic             w_ready;

    logic [PW-1:0]    v_fill;
    logic [15:0]      v_off;
    logic             v_blk;
    logic [13:0]      v_recs;
    logic [4:0]       v_hb;
    logic [15:0]      v_off_b;
    logic [PW-1:0]    v_next_b;
    t_result          v_res;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p,
                                              input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 >= len) ? '0 : PW'(p1);
    endfunction

    always_comb begin
        if (i_cfg.buffers_in_use == '0) begin
            w_len = CNT_W'(1);
        end else if (CNT_W'(i_cfg.buffers_in_use) > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = CNT_W'(i_cfg.buffers_in_use);
        end
    end

    assign w_size      = (17'(i_item.record_bytes) + 17'd3) & ~17'd3;
    assign w_need      = w_size + THB;
    assign w_room      = 18'(r_fill_off) + 18'(w_need);
    assign w_next_fill = next_ptr(r_filling, w_len);
    assign w_next_old  = next_ptr(r_oldest, w_len);
    assign w_ready     = r_blocked || (r_oldest != r_filling);

    always_comb begin
        n_oldest    = r_oldest;
        n_filling   = r_filling;
        n_fill_off  = r_fill_off;
        n_blocked   = r_blocked;
        n_lost_pend = r_lost_pend;
        n_offered   = r_offered;
        n_lost      = r_lost;
        n_size      = r_size;
        n_recs      = r_recs;
        n_blost     = r_blost;
        v_fill      = r_filling;
        v_off       = r_fill_off;
        v_blk       = r_blocked;
        v_recs      = r_recs[r_filling];
        v_hb        = '0;
        v_off_b     = '0;
        v_next_b    = '0;
        v_res        = '0;
        v_res.status = ST_IGNORED;

        case (i_item.opcode)
            OP_INSERT: begin
                v_res.buffer_index = 4'(r_filling);
                if (i_cfg.trace_enable) begin
                    if (r_offered != '1) n_offered = r_offered + 32'd1;
                    if (w_need > 17'(i_cfg.buffer_bytes)) begin
                        if (r_lost != '1) n_lost = r_lost + 32'd1;
                        if (r_lost_pend != '1) n_lost_pend = r_lost_pend + 16'd1;
                        v_res.status = ST_LOST_BIG;
                    end else begin
                        if (!r_blocked && (w_room > 18'(i_cfg.buffer_bytes))) begin
                            n_size[r_filling] = r_fill_off;
                            v_fill            = w_next_fill;
                            v_off             = '0;
                            v_blk             = (w_next_fill == r_oldest);
                            v_recs            = r_recs[w_next_fill];
                            v_res.flushed     = 1'b1;
                        end
                        v_res.buffer_index = 4'(v_fill);
                        n_filling          = v_fill;
                        n_fill_off         = v_off;
                        n_blocked          = v_blk;
                        if (v_blk) begin
                            if (r_lost != '1) n_lost = r_lost + 32'd1;
                            if (r_lost_pend != '1) n_lost_pend = r_lost_pend + 16'd1;
                            v_res.status = ST_LOST_BLOCKED;
                        end else begin
                            v_hb    = i_cfg.no_times ? HB_U : HB_T;
                            v_off_b = 16'(18'(v_off) + 18'(w_size) + 18'(v_hb));
                            v_res.header_bytes_used = v_hb;
                            v_res.write_offset      = v_off;
                            v_res.header_word       = 32'(w_size + 17'(v_hb))
                                                    | {i_item.record_flags, 16'h0000};
                            if (v_recs != '1) n_recs[v_fill] = v_recs + 14'd1;
                            n_fill_off   = v_off_b;
                            v_res.status = ST_STORED;
                            if (i_cfg.no_buf) begin
                                v_next_b       = next_ptr(v_fill, w_len);
                                n_size[v_fill] = v_off_b;
                                n_filling      = v_next_b;
                                n_fill_off     = '0;
                                n_blocked      = (v_next_b == r_oldest);
                                v_res.flushed  = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_DUMP, OP_DUMP_FORCE: begin
                if (!w_ready && (i_item.opcode == OP_DUMP)) begin
                    v_res.status = ST_NONE_READY;
                end else begin
                    v_res.status     = ST_DUMPED;
                    v_res.dump_bytes = r_size[r_oldest];
                    if (!w_ready) begin
                        n_size[r_filling] = r_fill_off;
                        n_fill_off        = '0;
                        n_filling         = w_next_fill;
                        v_res.flushed     = 1'b1;
                        v_res.status      = ST_FORCED;
                        v_res.dump_bytes  = r_fill_off;
                    end
                    v_res.buffer_index = 4'(r_oldest);
                    v_res.dump_records = r_recs[r_oldest];
                    v_res.dump_lost    = r_blost[r_oldest];
                    n_recs[r_oldest]   = '0;
                    n_blost[r_oldest]  = '0;
                    if (r_blocked) begin
                        n_blocked          = 1'b0;
                        n_blost[r_filling] = r_lost_pend;
                    end
                    n_lost_pend = '0;
                    n_oldest    = w_next_old;
                end
            end
            OP_RESET: begin
                n_oldest   = '0;
                n_filling  = '0;
                n_fill_off = '0;
                n_blocked  = 1'b0;
                n_offered  = '0;
                n_lost     = '0;
                for (int i = 0; i < MAX_BUFFERS; i++) begin
                    n_size[i]  = '0;
                    n_recs[i]  = '0;
                    n_blost[i] = '0;
                end
            end
            default: ;
        endcase

        v_res.total_records = n_offered;
        v_res.total_lost    = n_lost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_filling   <= '0;
            r_fill_off  <= '0;
            r_blocked   <= 1'b0;
            r_lost_pend <= '0;
            r_offered   <= '0;
            r_lost      <= '0;
            for (int i = 0; i < MAX_BUFFERS; i++) begin
                r_size[i]  <= '0;
                r_recs[i]  <= '0;
                r_blost[i] <= '0;
            end
        end else if (i_fire) begin
            r_oldest    <= n_oldest;
            r_filling   <= n_filling;
            r_fill_off  <= n_fill_off;
            r_blocked   <= n_blocked;
            r_lost_pend <= n_lost_pend;
            r_offered   <= n_offered;
            r_lost      <= n_lost;
            r_size      <= n_size;
            r_recs      <= n_recs;
            r_blost     <= n_blost;
        end
    end

    assign o_result = v_res;

endmodule

`default_nettype wire

>>> rtl/core/tbrc_out_stage.sv
// Result register of the trace buffer ring controller: holds and packs one word.
// Depends on tbrc_pkg.
`default_nettype none

module tbrc_out_stage
    import tbrc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire t_result                i_result,
    output logic                        o_ready,
    output logic                        o_tvalid,
    input  wire logic                   i_tready,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic [OUT_TUSER_W-1:0]      o_tuser
);

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_result.status;
    assign o_tdata  = {r_result.total_lost,
                       r_result.total_records,
                       r_result.dump_lost,
                       r_result.dump_records,
                       r_result.dump_bytes,
                       r_result.flushed,
                       r_result.header_bytes_used,
                       r_result.header_word,
                       r_result.write_offset,
                       r_result.buffer_index};

endmodule

`default_nettype wire

>>> test/trace_buffer_ring_controller_tb.sv
// Self-checking testbench for trace_buffer_ring_controller: directed and random trace words
// under several ring settings, with results predicted by a scoreboard class and compared.
// Depends on tbrc_pkg and the controller RTL.
module trace_buffer_ring_controller_tb;
    import tbrc_pkg::*;

    localparam int unsigned HDR_TIMED    = DEF_TIMED_HEADER_BYTES;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned HOLD_LEN     = 300;

    class ring_scoreboard;
        bit          te, nt, nb;
        bit [15:0]   buf_bytes;
        bit [4:0]    bufs_in_use;
        bit [3:0]    oldest, filling;
        bit [15:0]   fill_off;
        bit          blocked;
        bit [15:0]   lost_pend;
        bit [31:0]   offered, lost;
        bit [15:0]   sz[DEF_MAX_BUFFERS];
        bit [13:0]   recs[DEF_MAX_BUFFERS];
        bit [15:0]   blost[DEF_MAX_BUFFERS];
        t_result     want_q[$];
        int unsigned fails, checked, n_stored, n_lost, n_dumps, n_flush;

        function new();
            te = 1'b0;
            nt = 1'b0;
            nb = 1'b0;
            buf_bytes = RESET_BUFFER_BYTES;
            bufs_in_use = RESET_BUFFERS_IN_USE;
            lost_pend = '0;
            clear_ring();
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction

        function void clear_ring();
            oldest = '0;
            filling = '0;
            fill_off = '0;
            blocked = 1'b0;
            offered = '0;
            lost = '0;
            for (int i = 0; i < DEF_MAX_BUFFERS; i++) begin
                sz[i] = '0;
                recs[i] = '0;
                blost[i] = '0;
            end
        endfunction

        function int unsigned ring_len();
            int unsigned n;
            n = 32'(bufs_in_use);
            if (n == 0) return 1;
            if (n > DEF_MAX_BUFFERS) return DEF_MAX_BUFFERS;
            return n;
        endfunction

        function bit [3:0] advance(bit [3:0] p);
            int unsigned q;
            q = 32'(p);
            if (q + 1 >= ring_len()) return '0;
            return p + 4'd1;
        endfunction

        function void bump_lost();
            if (lost != '1) lost++;
            if (lost_pend != '1) lost_pend++;
        endfunction

        function void close_buf();
            sz[filling] = fill_off;
            filling = advance(filling);
            fill_off = '0;
            if (filling == oldest) blocked = 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
            case (idx)
                CFG_TRACE_ENABLE:   te = v[0];
                CFG_NO_TIMES:       nt = v[0];
                CFG_NO_BUF:         nb = v[0];
                CFG_BUFFER_BYTES:   buf_bytes = v;
                CFG_BUFFERS_IN_USE: bufs_in_use = v[4:0];
                default: ;
            endcase
        endfunction

        function void note_word(t_item it);
            t_result     r;
            int unsigned size, hb, off, limit;
            bit          ready;
            r = '0;
            r.status = ST_IGNORED;
            limit = 32'(buf_bytes);
            case (it.opcode)
                OP_INSERT: begin
                    r.buffer_index = filling;
                    if (te) begin
                        size = (int'(it.record_bytes) + 3) & ~32'd3;
                        if (offered != '1) offered++;
                        if (size + HDR_TIMED > limit) begin
                            bump_lost();
                            r.status = ST_LOST_BIG;
                        end else begin
                            off = 32'(fill_off);
                            if (!blocked && off + size + HDR_TIMED > limit) begin
                                close_buf();
                                r.flushed = 1'b1;
                            end
                            r.buffer_index = filling;
                            if (blocked) begin
                                bump_lost();
                                r.status = ST_LOST_BLOCKED;
                            end else begin
                                hb = nt ? UNTIMED_HEADER_BYTES : HDR_TIMED;
                                off = 32'(fill_off);
                                r.write_offset = fill_off;
                                r.header_word = (size + hb) | {it.record_flags, 16'h0000};
                                r.header_bytes_used = 5'(hb);
                                if (recs[filling] != '1) recs[filling]++;
                                fill_off = 16'(off + size + hb);
                                r.status = ST_STORED;
                                if (nb) begin
                                    close_buf();
                                    r.flushed = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_RESET: clear_ring();
                default: begin
                    ready = blocked || (oldest != filling);
                    if (!ready && it.opcode == OP_DUMP) begin
                        r.status = ST_NONE_READY;
                    end else begin
                        r.status = ST_DUMPED;
                        if (!ready) begin
                            sz[filling] = fill_off;
                            fill_off = '0;
                            filling = advance(filling);
                            r.flushed = 1'b1;
                            r.status = ST_FORCED;
                        end
                        r.buffer_index = oldest;
                        r.dump_bytes = sz[oldest];
                        r.dump_records = recs[oldest];
                        r.dump_lost = blost[oldest];
                        recs[oldest] = '0;
                        blost[oldest] = '0;
                        if (blocked) begin
                            blocked = 1'b0;
                            blost[filling] = lost_pend;
                        end
                        lost_pend = '0;
                        oldest = advance(oldest);
                    end
                end
            endcase
            r.total_records = offered;
            r.total_lost = lost;
            if (r.status == ST_STORED) n_stored++;
            if (r.status == ST_LOST_BIG || r.status == ST_LOST_BLOCKED) n_lost++;
            if (r.status == ST_DUMPED || r.status == ST_FORCED) n_dumps++;
            if (r.flushed) n_flush++;
            want_q.push_back(r);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fails++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (want_q.size() == 0) begin
                fails++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = want_q.pop_front();
            checked++;
            cmp_field("status", 32'(want.status), 32'(got.status));
            cmp_field("buffer_index", 32'(want.buffer_index), 32'(got.buffer_index));
            cmp_field("write_offset", 32'(want.write_offset), 32'(got.write_offset));
            cmp_field("header_word", want.header_word, got.header_word);
            cmp_field("header_bytes_used", 32'(want.header_bytes_used),
                      32'(got.header_bytes_used));
            cmp_field("flushed", 32'(want.flushed), 32'(got.flushed));
            cmp_field("dump_bytes", 32'(want.dump_bytes), 32'(got.dump_bytes));
            cmp_field("dump_records", 32'(want.dump_records), 32'(got.dump_records));
            cmp_field("dump_lost", 32'(want.dump_lost), 32'(got.dump_lost));
            cmp_field("total_records", want.total_records, got.total_records);
            cmp_field("total_lost", want.total_lost, got.total_lost);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // record_bytes[15:0], record_flags[31:16]
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // opcode[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // buffer_index[3:0], write_offset[19:4], header_word[51:20],
    // header_bytes_used[56:52], flushed[57], dump_bytes[73:58],
    // dump_records[87:74], dump_lost[103:88], total_records[135:104],
    // total_lost[167:136]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // status[2:0]

    ring_scoreboard sb;
    bit             calm;
    bit             hold_off;
    int unsigned    cycles;
    int unsigned    words_sent;
    int unsigned    settings_used;
    logic [15:0]    cur_bytes;

    trace_buffer_ring_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
        $display("FAIL");
        $finish;
    end

    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rx_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                int unsigned held;
                held = 0;
                m_axis_tready <= 1'b0;
                while (held < HOLD_LEN) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_off = 1'b0;
            end else if (calm || $urandom_range(0, 99) < 60) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (rx_stall()) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status            = t_status'(m_axis_tuser);
            got.buffer_index      = m_axis_tdata[3:0];
            got.write_offset      = m_axis_tdata[19:4];
            got.header_word       = m_axis_tdata[51:20];
            got.header_bytes_used = m_axis_tdata[56:52];
            got.flushed           = m_axis_tdata[57];
            got.dump_bytes        = m_axis_tdata[73:58];
            got.dump_records      = m_axis_tdata[87:74];
            got.dump_lost         = m_axis_tdata[103:88];
            got.total_records     = m_axis_tdata[135:104];
            got.total_lost        = m_axis_tdata[167:136];
            sb.check_result(got);
        end
    end

    task automatic send_word(t_opcode op, logic [15:0] nbytes, logic [15:0] flags);
        t_item it;
        int    gap;
        it.opcode = op;
        it.record_bytes = nbytes;
        it.record_flags = flags;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {flags, nbytes};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(it);
        words_sent++;
        gap = calm ? 0 : tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic set_config(bit te, bit nt, bit nb, logic [15:0] nbytes, logic [4:0] nbufs);
        drain();
        write_reg(CFG_TRACE_ENABLE, {15'd0, te});
        write_reg(CFG_NO_TIMES, {15'd0, nt});
        write_reg(CFG_NO_BUF, {15'd0, nb});
        write_reg(CFG_BUFFER_BYTES, nbytes);
        write_reg(CFG_BUFFERS_IN_USE, {11'd0, nbufs});
        i_cfg_we <= 1'b0;
        cur_bytes = nbytes;
        settings_used++;
    endtask

    task automatic run_random(int n_items, int dump_pct);
        t_opcode     op;
        logic [15:0] nbytes;
        int          r, cap;
        cap = (cur_bytes / 3 > 8) ? 32'(cur_bytes / 3) : 8;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) op = OP_RESET;
            else if (r < 2 + dump_pct * 2 / 3) op = OP_DUMP;
            else if (r < 2 + dump_pct) op = OP_DUMP_FORCE;
            else op = OP_INSERT;
            if (op != OP_INSERT || $urandom_range(0, 19) == 0) nbytes = 16'($urandom);
            else nbytes = 16'($urandom_range(0, cap));
            send_word(op, nbytes, 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        hold_off = 1'b0;
        words_sent = 0;
        settings_used = 1;
        cur_bytes = RESET_BUFFER_BYTES;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_TRACE_ENABLE;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_INSERT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'h0004, 16'h0000);
        send_word(OP_DUMP, 16'h0000, 16'h0000);

        set_config(1'b1, 1'b0, 1'b0, 16'd64, 5'd2);
        send_word(OP_DUMP, 16'h0000, 16'h0000);
        send_word(OP_DUMP_FORCE, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'd0, 16'hFFFF);
        send_word(OP_INSERT, 16'd1, 16'h0001);
        send_word(OP_INSERT, 16'hFFFF, 16'h8000);
        send_word(OP_INSERT, 16'd53, 16'h0000);
        send_word(OP_INSERT, 16'd52, 16'h1234);
        send_word(OP_INSERT, 16'd20, 16'h0000);
        send_word(OP_INSERT, 16'd20, 16'h0000);
        send_word(OP_DUMP, 16'h0000, 16'h0000);
        send_word(OP_DUMP_FORCE, 16'h0000, 16'h0000);
        send_word(OP_DUMP_FORCE, 16'h0000, 16'h0000);
        send_word(OP_DUMP, 16'h0000, 16'h0000);
        send_word(OP_RESET, 16'hFFFF, 16'hFFFF);
        send_word(OP_INSERT, 16'h00AA, 16'h5555);
        send_word(OP_DUMP_FORCE, 16'h0000, 16'h0000);

        set_config(1'b1, 1'b1, 1'b1, 16'd16, 5'd1);
        send_word(OP_INSERT, 16'd0, 16'hA5A5);
        send_word(OP_INSERT, 16'd2, 16'h0000);
        send_word(OP_DUMP, 16'h0000, 16'h0000);
        send_word(OP_INSERT, 16'd5, 16'h0000);
        send_word(OP_INSERT, 16'd4, 16'h00FF);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: set_config(1'b1, 1'b0, 1'b0, 16'd4096, 5'd16);
                1: set_config(1'b1, 1'b1, 1'b0, 16'd256, 5'd3);
                2: set_config(1'b1, 1'b0, 1'b1, 16'hFFFF, 5'd0);
                3: set_config(1'b1, 1'b1, 1'b1, 16'd0, 5'd31);
                4: set_config(1'b0, 1'b0, 1'b0, 16'd512, 5'd4);
                5: set_config(1'b1, 1'b0, 1'b0, 16'd16, 5'd17);
                6: set_config(1'b1, 1'b1, 1'b0, 16'd128, 5'd1);
                default: set_config(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    16'(($urandom_range(0, 5) == 0) ? 32'hFFFF
                                                                    : $urandom_range(16, 2048)),
                                    5'($urandom_range(0, 31)));
            endcase
            calm = (p == 0) || ($urandom_range(0, 3) == 0);
            if (p == 0) hold_off = 1'b1;
            run_random((p == 3 || p == 4) ? 25 : 62, $urandom_range(5, 35));
        end

        drain();
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        $display("covered %0d words over %0d register settings, %0d results checked",
                 words_sent, settings_used, sb.checked);
        $display("records stored %0d, lost %0d, buffers dumped %0d, flushes %0d",
                 sb.n_stored, sb.n_lost, sb.n_dumps, sb.n_flush);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
